// File: rtl/core/periodic_task_slot_scheduler_macros.svh
// Assertion helpers shared by the scheduler modules.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PTSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define PTSS_ASSERT_NEVER(lbl, cond, msg) \
  `PTSS_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/core/ptss_pkg.sv
package ptss_pkg;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned TASK_ID_BITS = 8;
  localparam int unsigned SLOT_BITS    = $clog2(SLOTS);
  localparam int unsigned TICK_BITS    = 16;
  localparam int unsigned PEND_BITS    = 8;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_DISP = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_DUE   = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_TICK = 4'b0100,
    ST_DISP = 4'b1000
  } state_e;

  typedef struct packed {
    opcode_e                 opcode;
    logic [TASK_ID_BITS-1:0] task_id;
    logic [TICK_BITS-1:0]    first_delay;
    logic [TICK_BITS-1:0]    repeat_period;
  } req_t;

  typedef struct packed {
    kind_e                   kind;
    logic [SLOT_BITS-1:0]    slot;
    logic [TASK_ID_BITS-1:0] due_task;
    logic                    last;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic add;
    logic tick;
    logic disp;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last_slot;
  } sts_t;

endpackage

// File: rtl/core/ptss_ctrl.sv
`include "periodic_task_slot_scheduler_macros.svh"

module ptss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ptss_pkg::opcode_e   opcode_i,
  input  ptss_pkg::sts_t      sts_i,
  output logic                busy,
  output ptss_pkg::cmd_t      cmd_o
);

  ptss_pkg::state_e state_q, state_d;
  logic             in_tick, in_disp;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ptss_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            ptss_pkg::OP_TICK: state_d = ptss_pkg::ST_TICK;
            ptss_pkg::OP_ADD:  state_d = ptss_pkg::ST_ADD;
            ptss_pkg::OP_DISP: state_d = ptss_pkg::ST_DISP;
            default:           state_d = ptss_pkg::ST_IDLE;
          endcase
        end
      end
      ptss_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ptss_pkg::ST_IDLE;
      end
      ptss_pkg::ST_TICK: begin
        cmd_o.tick = 1'b1;
        if (sts_i.last_slot) state_d = ptss_pkg::ST_IDLE;
      end
      ptss_pkg::ST_DISP: begin
        cmd_o.disp = 1'b1;
        if (sts_i.last_slot) state_d = ptss_pkg::ST_IDLE;
      end
      default: state_d = ptss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy    = (state_q != ptss_pkg::ST_IDLE);
  assign in_tick = (state_q == ptss_pkg::ST_TICK);
  assign in_disp = (state_q == ptss_pkg::ST_DISP);

  `PTSS_ASSERT(a_disp_holds, (in_disp && !sts_i.last_slot) |=> in_disp, "walk cut short")
  `PTSS_ASSERT(a_tick_ends, (in_tick && sts_i.last_slot) |=> !busy, "tick walk overran")
  `PTSS_ASSERT_NEVER(a_load_busy, cmd_o.load && busy, "request taken while busy")

endmodule

// File: rtl/core/ptss_dp.sv
`include "periodic_task_slot_scheduler_macros.svh"

module ptss_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptss_pkg::cmd_t  cmd_i,
  input  ptss_pkg::req_t  req_i,
  output ptss_pkg::sts_t  sts_o,
  output logic            res_valid_o,
  output ptss_pkg::res_t  res_o
);

  logic [ptss_pkg::TASK_ID_BITS-1:0] task_q [ptss_pkg::SLOTS];
  logic [ptss_pkg::TICK_BITS-1:0]    cd_q   [ptss_pkg::SLOTS];
  logic [ptss_pkg::TICK_BITS-1:0]    rel_q  [ptss_pkg::SLOTS];
  logic [ptss_pkg::PEND_BITS-1:0]    pend_q [ptss_pkg::SLOTS];

  logic [ptss_pkg::SLOTS-1:0]     occ_q, occ_d;
  logic [ptss_pkg::SLOTS-1:0]     due_q, due_d;
  logic [ptss_pkg::SLOT_BITS-1:0] idx_q;
  ptss_pkg::req_t                 req_q;
  ptss_pkg::res_t                 res_q, res_d;
  logic                           res_vld_q, res_vld_d;

  logic [ptss_pkg::TASK_ID_BITS-1:0] cur_task;
  logic [ptss_pkg::TICK_BITS-1:0]    cur_cd, cur_rel;
  logic [ptss_pkg::PEND_BITS-1:0]    cur_pend;

  logic                              wr_en;
  logic [ptss_pkg::SLOT_BITS-1:0]    wr_idx;
  logic [ptss_pkg::TASK_ID_BITS-1:0] wr_task;
  logic [ptss_pkg::TICK_BITS-1:0]    wr_cd, wr_rel;
  logic [ptss_pkg::PEND_BITS-1:0]    wr_pend;

  logic                           free_found;
  logic [ptss_pkg::SLOT_BITS-1:0] free_idx;
  logic                           due_above;

  assign cur_task = task_q[idx_q];
  assign cur_cd   = cd_q[idx_q];
  assign cur_rel  = rel_q[idx_q];
  assign cur_pend = pend_q[idx_q];

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = ptss_pkg::SLOTS - 1; j >= 0; j--) begin
      if (!occ_q[j]) begin
        free_found = 1'b1;
        free_idx   = ptss_pkg::SLOT_BITS'(j);
      end
    end
  end

  // Any due slot beyond the current one decides the last flag.
  always_comb begin
    due_above = 1'b0;
    for (int j = 0; j < ptss_pkg::SLOTS; j++) begin
      if (ptss_pkg::SLOT_BITS'(j) > idx_q && due_q[j]) due_above = 1'b1;
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = idx_q;
    wr_task   = cur_task;
    wr_cd     = cur_cd;
    wr_rel    = cur_rel;
    wr_pend   = cur_pend;
    occ_d     = occ_q;
    due_d     = due_q;
    res_vld_d = 1'b0;
    res_d     = '{kind: ptss_pkg::KIND_ADDED, slot: '0, due_task: '0, last: 1'b1};

    if (cmd_i.add) begin
      res_vld_d = 1'b1;
      if (free_found) begin
        wr_en            = 1'b1;
        wr_idx           = free_idx;
        wr_task          = req_q.task_id;
        wr_cd            = req_q.first_delay;
        wr_rel           = req_q.repeat_period;
        wr_pend          = '0;
        occ_d[free_idx]  = |req_q.task_id;
        due_d[free_idx]  = 1'b0;
        res_d.slot       = free_idx;
      end else begin
        res_d.kind = ptss_pkg::KIND_FULL;
      end
    end

    if (cmd_i.tick && occ_q[idx_q]) begin
      wr_en = 1'b1;
      if (cur_cd == '0) begin
        if (cur_pend != '1) wr_pend = cur_pend + 1'b1;
        if (cur_rel != '0) wr_cd = cur_rel;
      end else begin
        wr_cd = cur_cd - 1'b1;
      end
      due_d[idx_q] = |wr_pend;
    end

    if (cmd_i.disp) begin
      if (due_q[idx_q]) begin
        res_vld_d      = 1'b1;
        res_d.kind     = ptss_pkg::KIND_DUE;
        res_d.slot     = idx_q;
        res_d.due_task = cur_task;
        res_d.last     = !due_above;
        wr_en          = 1'b1;
        if (cur_rel == '0) begin
          // One-shot: free the slot and drop any remaining runs.
          wr_pend      = '0;
          occ_d[idx_q] = 1'b0;
          due_d[idx_q] = 1'b0;
        end else begin
          wr_pend      = cur_pend - 1'b1;
          due_d[idx_q] = |wr_pend;
        end
      end else if (idx_q == '0 && due_q == '0) begin
        res_vld_d  = 1'b1;
        res_d.kind = ptss_pkg::KIND_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      task_q[wr_idx] <= wr_task;
      cd_q[wr_idx]   <= wr_cd;
      rel_q[wr_idx]  <= wr_rel;
      pend_q[wr_idx] <= wr_pend;
    end
    if (cmd_i.load) req_q <= req_i;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      due_q     <= '0;
      idx_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      occ_q     <= occ_d;
      due_q     <= due_d;
      res_vld_q <= res_vld_d;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.tick || cmd_i.disp) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign sts_o.last_slot = (idx_q == ptss_pkg::SLOT_BITS'(ptss_pkg::SLOTS - 1));
  assign res_valid_o     = res_vld_q;
  assign res_o           = res_q;

  `PTSS_ASSERT_NEVER(a_due_free, |(due_q & ~occ_q), "free slot marked due")
  `PTSS_ASSERT(a_res_source, res_vld_q |-> $past(cmd_i.add || cmd_i.disp), "stray result")

endmodule

// File: rtl/core/periodic_task_slot_scheduler.sv
// Channel   Direction  Handshake                      Payload
// request   in         start high while busy low      req_i   (ptss_pkg::req_t)
// result    out        res_valid_o strobe, one cycle  res_o   (ptss_pkg::res_t)
//
// Add holds busy for one cycle; its result is registered from the add state and strobes from that register.
// Tick and dispatch hold busy while the walk visits all SLOTS (8) table slots, one slot per cycle,
// through a single read-modify-write of the slot registers.
// Opcode 3 is taken and dropped at once; busy stays low.
// Reset frees every slot at once through the occupied and due flags; no clearing pass.
// The receiver cannot stall: each result is on the ports for its strobe cycle only.
module periodic_task_slot_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  ptss_pkg::req_t req_i,
  output logic           busy,
  output logic           res_valid_o,
  output ptss_pkg::res_t res_o
);

  ptss_pkg::cmd_t cmd;
  ptss_pkg::sts_t sts;

  // Sequence the walk: one state per operation, the slot index lives in the datapath.
  ptss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (req_i.opcode),
    .sts_i    (sts),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // Hold the slot table, latch the request and register each result.
  ptss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
